### src/lbgc_pkg.sv
// Shared types, constants and tables of the laser beam to grid cells block.
package lbgc_pkg;

  localparam int CNT_W  = 6;
  localparam int RES_W  = 10;
  localparam int SIDE_W = 9;
  localparam int RNG_W  = 16;
  localparam int ANG_W  = 16;
  localparam int BEAM_W = 10;
  localparam int IDX_W  = 16;
  localparam int CFG_W  = 16;
  localparam int CADR_W = 3;
  localparam int DIV_W  = 20;
  localparam int TRIG_W = 20;
  localparam int PHI_W  = 20;
  localparam int CRD_W  = 21;
  localparam int TH_W   = 31;
  localparam int RED_W  = 30;
  localparam int NUM_W  = 40;
  localparam int ACC_W  = 32;
  localparam int HRES_W = 18;

  localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
  localparam logic [18:0] PI_Q16     = 19'd205887;
  localparam logic signed [PHI_W-1:0] PI_S       = 20'sd205887;
  localparam logic signed [PHI_W-1:0] HALF_PI_S  = 20'sd102944;
  localparam logic signed [PHI_W-1:0] MHALF_PI_S = -20'sd102944;
  localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 20'sd39797;
  localparam logic [3:0] MOD_STEPS_M1 = 4'd10;
  localparam logic [3:0] CORDIC_LAST  = 4'd15;

  typedef enum logic [CADR_W-1:0] {
    REG_CELL_SIZE   = 3'd0,
    REG_MAP_WIDTH   = 3'd1,
    REG_MAP_HEIGHT  = 3'd2,
    REG_RANGE_LIMIT = 3'd3,
    REG_START_ANGLE = 3'd4,
    REG_ANGLE_STEP  = 3'd5
  } reg_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_THETA, ST_ABS, ST_MOD, ST_WRAP, ST_FOLD, ST_CORDIC, ST_TRIG,
    ST_DIVN, ST_WAITN, ST_MULX, ST_DIVX, ST_WAITX, ST_MULY, ST_DIVY, ST_WAITY,
    ST_OCC, ST_FREE
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_THETA, OP_ABS, OP_MOD, OP_WRAP, OP_FOLD, OP_CORDIC,
    OP_TRIG, OP_DIVN, OP_WAITN, OP_MULX, OP_DIVX, OP_WAITX, OP_MULY, OP_DIVY,
    OP_WAITY, OP_OCC, OP_FREE
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic reject;
    logic div_done;
    logic no_free;
    logic free_last;
  } sts_t;

  function automatic logic [16:0] atan_q16(input logic [3:0] i);
    logic [16:0] v;
    unique case (i)
      4'd0:  v = 17'd51472;
      4'd1:  v = 17'd30386;
      4'd2:  v = 17'd16055;
      4'd3:  v = 17'd8150;
      4'd4:  v = 17'd4091;
      4'd5:  v = 17'd2047;
      4'd6:  v = 17'd1024;
      4'd7:  v = 17'd512;
      4'd8:  v = 17'd256;
      4'd9:  v = 17'd128;
      4'd10: v = 17'd64;
      4'd11: v = 17'd32;
      4'd12: v = 17'd16;
      4'd13: v = 17'd8;
      4'd14: v = 17'd4;
      default: v = 17'd2;
    endcase
    return v;
  endfunction

endpackage

### src/lbgc_div.sv
// Restoring divider, one quotient bit per cycle.
module lbgc_div import lbgc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [RES_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  logic [RES_W-1:0] rem_q, rem_d, dvs_q;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [4:0]       cnt_q;
  logic             run_q, done_q;
  logic [RES_W:0]   trial;
  logic             bit_c;

  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    bit_c = (trial >= {1'b0, dvs_q});
    rem_d = bit_c ? RES_W'(trial - {1'b0, dvs_q}) : trial[RES_W-1:0];
    quo_d = {quo_q[DIV_W-2:0], bit_c};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 5'(DIV_W - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### src/lbgc_ctrl.sv
// Sequencer that steps the datapath through one beam.
module lbgc_ctrl import lbgc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy
);

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (start) state_d = ST_THETA;
      ST_THETA:  state_d = sts_i.reject ? ST_IDLE : ST_ABS;
      ST_ABS:    state_d = ST_MOD;
      ST_MOD:    if (cnt_q == '0) state_d = ST_WRAP;
      ST_WRAP:   state_d = ST_FOLD;
      ST_FOLD:   state_d = ST_CORDIC;
      ST_CORDIC: if (cnt_q[3:0] == CORDIC_LAST) state_d = ST_TRIG;
      ST_TRIG:   state_d = ST_DIVN;
      ST_DIVN:   state_d = ST_WAITN;
      ST_WAITN:  if (sts_i.div_done) state_d = ST_MULX;
      ST_MULX:   state_d = ST_DIVX;
      ST_DIVX:   state_d = ST_WAITX;
      ST_WAITX:  if (sts_i.div_done) state_d = ST_MULY;
      ST_MULY:   state_d = ST_DIVY;
      ST_DIVY:   state_d = ST_WAITY;
      ST_WAITY:  if (sts_i.div_done) state_d = ST_OCC;
      ST_OCC:    state_d = sts_i.no_free ? ST_IDLE : ST_FREE;
      ST_FREE:   if (sts_i.free_last) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    unique case (state_q)
      ST_ABS:    cnt_d = CNT_W'(MOD_STEPS_M1);
      ST_MOD:    cnt_d = cnt_q - 1'b1;
      ST_FOLD:   cnt_d = '0;
      ST_CORDIC: cnt_d = cnt_q + 1'b1;
      ST_OCC:    cnt_d = '0;
      ST_FREE:   cnt_d = cnt_q + 1'b1;
      default:   cnt_d = cnt_q;
    endcase
  end

  always_comb begin
    cmd_o.cnt = cnt_q;
    busy      = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE:   cmd_o.op = start ? OP_LOAD : OP_NONE;
      ST_THETA:  cmd_o.op = OP_THETA;
      ST_ABS:    cmd_o.op = OP_ABS;
      ST_MOD:    cmd_o.op = OP_MOD;
      ST_WRAP:   cmd_o.op = OP_WRAP;
      ST_FOLD:   cmd_o.op = OP_FOLD;
      ST_CORDIC: cmd_o.op = OP_CORDIC;
      ST_TRIG:   cmd_o.op = OP_TRIG;
      ST_DIVN:   cmd_o.op = OP_DIVN;
      ST_WAITN:  cmd_o.op = OP_WAITN;
      ST_MULX:   cmd_o.op = OP_MULX;
      ST_DIVX:   cmd_o.op = OP_DIVX;
      ST_WAITX:  cmd_o.op = OP_WAITX;
      ST_MULY:   cmd_o.op = OP_MULY;
      ST_DIVY:   cmd_o.op = OP_DIVY;
      ST_WAITY:  cmd_o.op = OP_WAITY;
      ST_OCC:    cmd_o.op = OP_OCC;
      ST_FREE:   cmd_o.op = OP_FREE;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

endmodule

### src/lbgc_dp.sv
// Datapath: configuration, angle reduction, CORDIC, cell mapping and result register.
module lbgc_dp import lbgc_pkg::*; #(
  parameter int MAX_SIDE       = 256,
  parameter int MAX_FREE_CELLS = 62,
  parameter int MAX_BEAMS      = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [BEAM_W-1:0] beam_index_i,
  input  logic [RNG_W-1:0]  range_mm_i,
  input  logic              cfg_we_i,
  input  logic [CADR_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output logic              valid_o,
  output logic [IDX_W-1:0]  cell_index_o,
  output logic              occupied_o,
  output logic              in_map_o,
  output logic              last_o
);

  logic [RES_W-1:0]  res_q;
  logic [SIDE_W-1:0] mapw_q, maph_q;
  logic [RNG_W-1:0]  lim_q;
  logic signed [ANG_W-1:0] sa_q, step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q  <= 10'd100;
      mapw_q <= 9'd120;
      maph_q <= 9'd120;
      lim_q  <= 16'd6000;
      sa_q   <= -16'sd25736;
      step_q <= 16'sd143;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CELL_SIZE:   res_q  <= cfg_data_i[RES_W-1:0];
        REG_MAP_WIDTH:   mapw_q <= cfg_data_i[SIDE_W-1:0];
        REG_MAP_HEIGHT:  maph_q <= cfg_data_i[SIDE_W-1:0];
        REG_RANGE_LIMIT: lim_q  <= cfg_data_i;
        REG_START_ANGLE: sa_q   <= $signed(cfg_data_i);
        REG_ANGLE_STEP:  step_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  logic [RES_W-1:0]  res_e;
  logic [SIDE_W-1:0] w_e, h_e;
  logic [7:0]        hx, hy;

  always_comb begin
    res_e = (res_q == '0) ? RES_W'(1) : res_q;
    if (mapw_q < SIDE_W'(2))             w_e = SIDE_W'(2);
    else if (mapw_q > SIDE_W'(MAX_SIDE)) w_e = SIDE_W'(MAX_SIDE);
    else                                 w_e = mapw_q;
    if (maph_q < SIDE_W'(2))             h_e = SIDE_W'(2);
    else if (maph_q > SIDE_W'(MAX_SIDE)) h_e = SIDE_W'(MAX_SIDE);
    else                                 h_e = maph_q;
    hx = h_e[8:1];
    hy = w_e[8:1];
  end

  logic [BEAM_W-1:0] beam_q;
  logic [RNG_W-1:0]  range_q;
  logic signed [TH_W-1:0]   th8_q;
  logic [RED_W-1:0]         r_q;
  logic                     neg_q;
  logic signed [PHI_W-1:0]  phi_q;
  logic                     flip_q;
  logic signed [TRIG_W-1:0] x_q, y_q, cos_q, sin_q;
  logic [HRES_W-1:0]        hresx_q, hresy_q;
  logic [CNT_W-1:0]         steps_q;
  logic signed [NUM_W-1:0]  num_q;
  logic                     numneg_q;
  logic signed [CRD_W-1:0]  colo_q, rowo_q;
  logic signed [ACC_W-1:0]  accx_q, accy_q;

  logic                     div_start, div_done;
  logic [DIV_W-1:0]         div_dividend, div_q;
  logic [RES_W-1:0]         div_divisor;

  logic signed [BEAM_W+ANG_W:0] bprod;
  logic signed [BEAM_W+ANG_W+1:0] theta_c;
  logic [RED_W-1:0]         msh;
  logic [18:0]              pw;
  logic [3:0]               ci;
  logic signed [TRIG_W-1:0] dx, dy;
  logic signed [PHI_W-1:0]  at;
  logic signed [TRIG_W-1:0] trig_sel;
  logic [HRES_W-1:0]        hres_sel;
  logic signed [NUM_W-1:0]  num_c;
  logic [NUM_W-1:0]         num_abs;
  logic [DIV_W-1:0]         q16;
  logic [DIV_W-1:0]         nm1;
  logic signed [CRD_W-1:0]  qs;

  assign bprod   = $signed({1'b0, beam_q}) * step_q;
  assign theta_c = (BEAM_W+ANG_W+2)'(bprod) + (BEAM_W+ANG_W+2)'(sa_q);
  assign msh     = RED_W'({11'd0, TWO_PI_Q16} << cmd_i.cnt[3:0]);
  assign pw      = (neg_q && (r_q != '0)) ? (TWO_PI_Q16 - r_q[18:0]) : r_q[18:0];
  assign ci      = cmd_i.cnt[3:0];
  assign dx      = y_q >>> ci;
  assign dy      = x_q >>> ci;
  assign at      = $signed({3'b000, atan_q16(ci)});
  assign trig_sel = (cmd_i.op == OP_MULY) ? sin_q : cos_q;
  assign hres_sel = (cmd_i.op == OP_MULY) ? hresy_q : hresx_q;
  assign num_c   = NUM_W'($signed({1'b0, range_q}) * trig_sel)
                 + $signed({6'd0, hres_sel, 16'd0});
  assign num_abs = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
  assign q16     = {4'd0, div_q[15:0]};
  assign nm1     = (q16 == '0) ? '0 : q16 - DIV_W'(1);
  assign qs      = numneg_q ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

  always_comb begin
    div_start    = 1'b0;
    div_dividend = {4'd0, range_q};
    div_divisor  = res_e;
    if (cmd_i.op == OP_DIVN) begin
      div_start = 1'b1;
    end else if (cmd_i.op == OP_DIVX || cmd_i.op == OP_DIVY) begin
      div_start    = 1'b1;
      div_dividend = num_abs[35:16];
    end
  end

  lbgc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        beam_q  <= beam_index_i;
        range_q <= range_mm_i;
      end
      OP_THETA: th8_q <= {theta_c[TH_W-4:0], 3'b000};
      OP_ABS: begin
        neg_q <= th8_q[TH_W-1];
        r_q   <= th8_q[TH_W-1] ? RED_W'(-th8_q) : RED_W'(th8_q);
      end
      OP_MOD: if (r_q >= msh) r_q <= r_q - msh;
      OP_WRAP: begin
        if (pw >= PI_Q16) phi_q <= $signed({1'b0, pw}) - $signed({1'b0, TWO_PI_Q16});
        else              phi_q <= $signed({1'b0, pw});
      end
      OP_FOLD: begin
        x_q <= CORDIC_X0;
        y_q <= '0;
        if (phi_q > HALF_PI_S) begin
          phi_q  <= phi_q - PI_S;
          flip_q <= 1'b1;
        end else if (phi_q < MHALF_PI_S) begin
          phi_q  <= phi_q + PI_S;
          flip_q <= 1'b1;
        end else begin
          flip_q <= 1'b0;
        end
      end
      OP_CORDIC: begin
        if (phi_q >= 0) begin
          x_q   <= x_q - dx;
          y_q   <= y_q + dy;
          phi_q <= phi_q - at;
        end else begin
          x_q   <= x_q + dx;
          y_q   <= y_q - dy;
          phi_q <= phi_q + at;
        end
      end
      OP_TRIG: begin
        cos_q   <= flip_q ? -x_q : x_q;
        sin_q   <= flip_q ? -y_q : y_q;
        hresx_q <= HRES_W'(hx * res_e);
        hresy_q <= HRES_W'(hy * res_e);
      end
      OP_WAITN: begin
        if (div_done) begin
          if (nm1 > DIV_W'(MAX_FREE_CELLS)) steps_q <= CNT_W'(MAX_FREE_CELLS);
          else                              steps_q <= nm1[CNT_W-1:0];
        end
      end
      OP_MULX, OP_MULY: num_q <= num_c;
      OP_DIVX, OP_DIVY: numneg_q <= num_q[NUM_W-1];
      OP_WAITX: if (div_done) colo_q <= qs;
      OP_WAITY: if (div_done) rowo_q <= qs;
      OP_OCC: begin
        accx_q <= $signed({8'd0, hx, 16'd0});
        accy_q <= $signed({8'd0, hy, 16'd0});
      end
      OP_FREE: begin
        accx_q <= accx_q + ACC_W'(cos_q);
        accy_q <= accy_q + ACC_W'(sin_q);
      end
      default: ;
    endcase
  end

  assign sts_o.reject    = (32'(beam_q) >= 32'(MAX_BEAMS)) || (range_q >= lim_q);
  assign sts_o.div_done  = div_done;
  assign sts_o.no_free   = (steps_q == '0);
  assign sts_o.free_last = (cmd_i.cnt == steps_q - 1'b1);

  logic signed [ACC_W-1:0] fx_p, fy_p;
  logic signed [CRD_W-1:0] col_c, row_c;
  logic                    in_map_c, emit;
  logic [IDX_W:0]          idx_c;

  always_comb begin
    fx_p = accx_q[ACC_W-1] ? -accx_q : accx_q;
    fy_p = accy_q[ACC_W-1] ? -accy_q : accy_q;
    if (cmd_i.op == OP_OCC) begin
      col_c = colo_q;
      row_c = rowo_q;
    end else begin
      col_c = accx_q[ACC_W-1] ? -CRD_W'(fx_p >>> 16) : CRD_W'(fx_p >>> 16);
      row_c = accy_q[ACC_W-1] ? -CRD_W'(fy_p >>> 16) : CRD_W'(fy_p >>> 16);
    end
    in_map_c = (col_c >= 0) && (col_c < $signed(CRD_W'(w_e)))
            && (row_c >= 0) && (row_c < $signed(CRD_W'(h_e)));
    idx_c  = (IDX_W+1)'(col_c[7:0]) + (IDX_W+1)'(row_c[7:0] * w_e);
    emit   = (cmd_i.op == OP_OCC) || (cmd_i.op == OP_FREE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else         valid_o <= emit;
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      cell_index_o <= in_map_c ? idx_c[IDX_W-1:0] : '0;
      in_map_o     <= in_map_c;
      occupied_o   <= (cmd_i.op == OP_OCC);
      last_o       <= (cmd_i.op == OP_OCC) ? sts_o.no_free : sts_o.free_last;
    end
  end

endmodule

### src/laser_beam_to_grid_cells_top.sv
// Top level of the laser beam to grid cells ray caster.
// One request (a beam index and its range) is taken when start is high and busy
// is low. A beam at or beyond the range limit, or with an index past the scan,
// ends with no result. Otherwise the occupied cell appears after an 11-step
// angle reduction, a 16-step CORDIC and three runs of a shared 20-step
// restoring divider. The free cells then follow one per cycle, and busy falls
// with the last one. Each result is shown for a single cycle with valid_o high
// and must be taken then; the final cell of a beam carries last_o.
module laser_beam_to_grid_cells_top import lbgc_pkg::*; #(
  parameter int MAX_SIDE       = 256,
  parameter int MAX_FREE_CELLS = 62,
  parameter int MAX_BEAMS      = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [BEAM_W-1:0] beam_index_i,
  input  logic [RNG_W-1:0]  range_mm_i,
  input  logic              cfg_we_i,
  input  logic [CADR_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output logic              valid_o,
  output logic [IDX_W-1:0]  cell_index_o,
  output logic              occupied_o,
  output logic              in_map_o,
  output logic              last_o
);

  cmd_t cmd;
  sts_t sts;

  lbgc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  lbgc_dp #(
    .MAX_SIDE       (MAX_SIDE),
    .MAX_FREE_CELLS (MAX_FREE_CELLS),
    .MAX_BEAMS      (MAX_BEAMS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .beam_index_i (beam_index_i),
    .range_mm_i   (range_mm_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .valid_o      (valid_o),
    .cell_index_o (cell_index_o),
    .occupied_o   (occupied_o),
    .in_map_o     (in_map_o),
    .last_o       (last_o)
  );

endmodule

### src/lbgc_chk.sv
// Port level checks of the ray caster and their binding to the top level.
module lbgc_chk import lbgc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              valid_o,
  input logic [IDX_W-1:0]  cell_index_o,
  input logic              in_map_o,
  input logic              last_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("request accepted but busy stayed low");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> busy) else $error("non-final cell while idle");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !in_map_o |-> cell_index_o == '0) else $error("outside cell has index");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |=> !valid_o) else $error("cell right after final cell");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && !start |=> !valid_o) else $error("cell while idle");

endmodule

bind laser_beam_to_grid_cells_top lbgc_chk u_lbgc_chk (.*);

### tb/testbench.sv
// Self-checking testbench for the laser beam to grid cells ray caster.
module testbench;
  import lbgc_pkg::*;

  localparam logic [CADR_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CADR_W-1:0] REG_SPARE_B = 3'd7;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 200;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             occupied;
    logic             in_map;
    logic             last;
  } grid_cell_t;

  class cell_scoreboard;
    grid_cell_t     pending_cells[$];
    int             errors;
    int             beams_cast;
    int             beams_dropped;
    int             cells_seen;
    longint         cell_size;
    longint         map_width;
    longint         map_height;
    longint         range_limit;
    logic [15:0]    start_angle;
    logic [15:0]    angle_step;
    longint         arctan[16];

    function new();
      arctan = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                 256, 128, 64, 32, 16, 8, 4, 2};
      cell_size   = 100;
      map_width   = 120;
      map_height  = 120;
      range_limit = 6000;
      start_angle = -16'sd25736;
      angle_step  = 16'sd143;
    endfunction

    function void write_reg(logic [CADR_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_CELL_SIZE:   cell_size = data[9:0];
        REG_MAP_WIDTH:   map_width = data[8:0];
        REG_MAP_HEIGHT:  map_height = data[8:0];
        REG_RANGE_LIMIT: range_limit = data;
        REG_START_ANGLE: start_angle = data;
        REG_ANGLE_STEP:  angle_step = data;
        default: ;
      endcase
    endfunction

    function longint side(longint v);
      if (v < 2) return 2;
      if (v > 256) return 256;
      return v;
    endfunction

    function void rotate(longint theta, output longint cs, output longint sn);
      longint phi, x, y, dx, dy;
      bit flip;
      phi = (theta * 8) % 411775;
      x = 39797;
      y = 0;
      flip = 0;
      if (phi < 0) phi += 411775;
      if (phi >= 205887) phi -= 411775;
      if (phi > 102944) begin
        phi -= 205887;
        flip = 1;
      end else if (phi < -102944) begin
        phi += 205887;
        flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (phi >= 0) begin
          x -= dx;
          y += dy;
          phi -= arctan[i];
        end else begin
          x += dx;
          y -= dy;
          phi += arctan[i];
        end
      end
      cs = flip ? -x : x;
      sn = flip ? -y : y;
    endfunction

    function void push_cell(longint col, longint row, longint w, longint h, bit occ);
      grid_cell_t entry;
      bit on_map;
      on_map = col >= 0 && col < w && row >= 0 && row < h;
      entry.index    = on_map ? IDX_W'(col + row * w) : '0;
      entry.occupied = occ;
      entry.in_map   = on_map;
      entry.last     = 1'b0;
      pending_cells.push_back(entry);
    endfunction

    // Works out every cell write that an accepted request causes.
    function void note_request(logic [BEAM_W-1:0] beam, logic [RNG_W-1:0] rng);
      longint r, res, w, h, theta, cs, sn, steps, d, den;
      r = rng;
      if (r >= range_limit) begin
        beams_dropped++;
        return;
      end
      beams_cast++;
      res = (cell_size == 0) ? 1 : cell_size;
      w = side(map_width);
      h = side(map_height);
      den = res * 65536;
      theta = longint'($signed(start_angle)) + longint'(beam) * longint'($signed(angle_step));
      rotate(theta, cs, sn);
      push_cell((r * cs + (h / 2) * den) / den, (r * sn + (w / 2) * den) / den, w, h, 1);
      steps = r / res - 1;
      if (steps < 0) steps = 0;
      if (steps > 62) steps = 62;
      for (longint n = 0; n < steps; n++) begin
        d = n * res;
        push_cell((d * cs + (h / 2) * den) / den, (d * sn + (w / 2) * den) / den, w, h, 0);
      end
      pending_cells[$].last = 1'b1;
    endfunction

    function void check_result(grid_cell_t got);
      grid_cell_t want;
      cells_seen++;
      if (pending_cells.size() == 0) begin
        $display("%0t: unexpected cell write idx=%0d occ=%0b in_map=%0b last=%0b",
                 $time, got.index, got.occupied, got.in_map, got.last);
        errors++;
        return;
      end
      want = pending_cells.pop_front();
      if (got.index !== want.index) begin
        $display("%0t: cell_index expected %0d actual %0d", $time, want.index, got.index);
        errors++;
      end
      if (got.occupied !== want.occupied) begin
        $display("%0t: occupied expected %0b actual %0b", $time, want.occupied, got.occupied);
        errors++;
      end
      if (got.in_map !== want.in_map) begin
        $display("%0t: in_map expected %0b actual %0b", $time, want.in_map, got.in_map);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [BEAM_W-1:0] beam_index_i;
  logic [RNG_W-1:0]  range_mm_i;
  logic              cfg_we_i;
  logic [CADR_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]  cfg_data_i;
  logic              valid_o;
  logic [IDX_W-1:0]  cell_index_o;
  logic              occupied_o;
  logic              in_map_o;
  logic              last_o;

  cell_scoreboard grid_sb;
  int idle_cycles;
  int send_idle_pct;

  laser_beam_to_grid_cells_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .beam_index_i (beam_index_i),
    .range_mm_i   (range_mm_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .valid_o      (valid_o),
    .cell_index_o (cell_index_o),
    .occupied_o   (occupied_o),
    .in_map_o     (in_map_o),
    .last_o       (last_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      grid_sb.check_result('{cell_index_o, occupied_o, in_map_o, last_o});
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || valid_o || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired at %0t", $time);
      $display("laser_beam_to_grid_cells_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_beam(logic [BEAM_W-1:0] beam, logic [RNG_W-1:0] rng);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    start = 1'b1;
    beam_index_i = beam;
    range_mm_i = rng;
    grid_sb.note_request(beam, rng);
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (busy || grid_sb.pending_cells.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CADR_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    grid_sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic setup_map(int res, int w, int h, int lim, int sa, int st);
    wait_idle();
    write_reg(REG_CELL_SIZE, CFG_W'(res));
    write_reg(REG_MAP_WIDTH, CFG_W'(w));
    write_reg(REG_MAP_HEIGHT, CFG_W'(h));
    write_reg(REG_RANGE_LIMIT, CFG_W'(lim));
    write_reg(REG_START_ANGLE, CFG_W'(sa));
    write_reg(REG_ANGLE_STEP, CFG_W'(st));
  endtask

  // Mostly ranges up to just past the start of the free-cell saturation region, some noise.
  task automatic random_beams(int count);
    longint res, top, rng;
    for (int k = 0; k < count; k++) begin
      res = (grid_sb.cell_size == 0) ? 1 : grid_sb.cell_size;
      top = 65 * res;
      if (top > grid_sb.range_limit - 1) top = grid_sb.range_limit - 1;
      case ($urandom_range(9))
        0: rng = $urandom_range(65535);
        1: rng = grid_sb.range_limit + $urandom_range(3) - 1;
        default: rng = (top < 0) ? $urandom_range(65535) : $urandom_range(top);
      endcase
      if (rng < 0) rng = 0;
      if (rng > 65535) rng = 65535;
      send_beam(BEAM_W'($urandom_range(1023)), RNG_W'(rng));
    end
  endtask

  initial begin
    grid_sb = new();
    rst_ni = 1'b0;
    start = 1'b0;
    beam_index_i = '0;
    range_mm_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_CELL_SIZE;
    cfg_data_i = '0;
    idle_cycles = 0;
    send_idle_pct = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_beam(10'd0, 16'd0);
    send_beam(10'd1023, 16'd5999);
    send_beam(10'd5, 16'd6000);
    send_beam(10'd5, 16'd65535);
    send_beam(10'd300, 16'd150);
    send_beam(10'd301, 16'd200);
    send_beam(10'd180, 16'd5000);
    wait_idle();
    write_reg(REG_SPARE_A, 16'hFFFF);
    write_reg(REG_SPARE_B, 16'h0000);
    send_beam(10'd512, 16'd3000);
    setup_map(0, 0, 1, 65535, 32767, -32768);
    send_beam(10'd1, 16'd40);
    send_beam(10'd1022, 16'd7);
    setup_map(10, 257, 511, 65535, -32768, 32767);
    send_beam(10'd0, 16'd65534);
    send_beam(10'd700, 16'd2000);
    setup_map(1023, 256, 256, 65535, 0, 1);
    send_beam(10'd1023, 16'd65534);
    send_beam(10'd3, 16'd2046);

    setup_map(100, 120, 120, 6000, -25736, 143);
    send_idle_pct = 0;
    random_beams(50);
    setup_map(37, 64, 200, 3000, 0, 50);
    send_idle_pct = 63;
    random_beams(50);
    setup_map(1000, 2, 256, 65535, -1000, -7);
    send_idle_pct = 0;
    random_beams(50);
    setup_map(1, 17, 9, 100, 12000, -300);
    send_idle_pct = 20;
    random_beams(50);

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Cast %0d beams (%0d dropped) and checked %0d cell writes.",
             grid_sb.beams_cast, grid_sb.beams_dropped, grid_sb.cells_seen);
    $display("Map settings covered resolution and side extremes and sender idle phases.");
    if (grid_sb.errors == 0 && grid_sb.pending_cells.size() == 0) begin
      $display("laser_beam_to_grid_cells_top test passed");
    end else begin
      $display("laser_beam_to_grid_cells_top test failed");
    end
    $finish;
  end

endmodule

### files.f
src/lbgc_pkg.sv
src/lbgc_div.sv
src/lbgc_ctrl.sv
src/lbgc_dp.sv
src/laser_beam_to_grid_cells_top.sv
src/lbgc_chk.sv
tb/testbench.sv
